>>> rtl/cobs_frame_decoder_assert.svh
// Assertion macros for the COBS frame decoder checker.
// No dependencies; included by the checker file.
`ifndef COBS_FRAME_DECODER_ASSERT_SVH
`define COBS_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define COBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cobs decoder check failed");

// Next-cycle implication, held off during reset.
`define COBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cobs decoder check failed");

`endif

>>> rtl/cobs_pkg.sv
// Shared types and constants for the COBS frame decoder.
// No dependencies; used by cobs_step and cobs_frame_decoder.
package cobs_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_OUT_W = 16;
    localparam logic [BYTE_W-1:0] FULL_CODE = 8'hFF;
    localparam logic [BYTE_W-1:0] END_CODE = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              frame_last;
    } cobs_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic                 has_byte;
        logic                 frame_end;
        logic [LEN_OUT_W-1:0] decoded_length;
    } cobs_result_t;

endpackage

>>> rtl/cobs_frame_decoder.sv
// Top level of the streaming COBS frame decoder: input register, decode step, result register.
// Depends on cobs_pkg and cobs_step.
//
// Streaming COBS decoder. One encoded byte is taken per cycle; each byte goes into an
// input register, is decoded against the frame state, and lands in a result register.
// A new byte can be taken every cycle as long as the result side keeps up; the frame
// state update in cobs_step on every advance allows that rate. Bytes that decode to
// nothing (code bytes with no reserved byte due, bytes after a zero code) produce no
// output transfer. The byte flagged frame_last always produces one result with
// frame_end set and the decoded length, saturated at 2^LENGTH_BITS - 1 and shown
// clamped to 16 bits. The reserved byte register is written through the cfg channel,
// which is always ready; write it only while idle.
module cobs_frame_decoder #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        frame_end,
    output logic [15:0] decoded_length
);
    import cobs_pkg::*;

    logic [BYTE_W-1:0] reserved_reg;
    logic              stage_valid_reg;
    cobs_item_t        stage_reg;
    logic              out_valid_reg;
    cobs_result_t      out_reg;
    logic              advance;
    logic              emit;
    cobs_result_t      result;

    assign cfg_ready = 1'b1;
    assign advance   = stage_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reserved_reg <= cfg_data;
        end
    end

    // Hold the accepted byte until the decode step consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg.in_byte    <= in_byte;
            stage_reg.frame_last <= frame_last;
        end
    end

    cobs_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .reserved_byte (reserved_reg),
        .item          (stage_reg),
        .advance       (advance),
        .emit          (emit),
        .result        (result)
    );

    // Load a new result on an advance that emits; drop the old one once transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_reg.out_byte;
    assign has_byte       = out_reg.has_byte;
    assign frame_end      = out_reg.frame_end;
    assign decoded_length = out_reg.decoded_length;

endmodule

>>> rtl/cobs_step.sv
// Frame state and per-byte decode step of the COBS frame decoder.
// Depends on cobs_pkg for the item and result types.
module cobs_step #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                reserved_byte,
    input  cobs_pkg::cobs_item_t      item,
    input  logic                      advance,
    output logic                      emit,
    output cobs_pkg::cobs_result_t    result
);
    import cobs_pkg::*;

    logic [BYTE_W-1:0]      bytes_left_reg;
    logic [BYTE_W-1:0]      bytes_left_next;
    logic                   insert_pending_reg;
    logic                   insert_pending_next;
    logic                   stopped_reg;
    logic                   stopped_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_upd;
    logic [LENGTH_BITS-1:0] count_next;
    logic                   has;
    logic [BYTE_W-1:0]      ob;
    logic [LEN_OUT_W-1:0]   len_clamped;

    always_comb
    begin
        has                 = 1'b0;
        ob                  = '0;
        bytes_left_next     = bytes_left_reg;
        insert_pending_next = insert_pending_reg;
        stopped_next        = stopped_reg;
        if (!stopped_reg)
        begin
            if (bytes_left_reg != '0)
            begin
                has             = 1'b1;
                ob              = item.in_byte;
                bytes_left_next = bytes_left_reg - 8'd1;
            end
            else if (item.in_byte == END_CODE)
            begin
                stopped_next        = 1'b1;
                insert_pending_next = 1'b0;
            end
            else
            begin
                has                 = insert_pending_reg;
                ob                  = insert_pending_reg ? reserved_byte : '0;
                bytes_left_next     = item.in_byte - 8'd1;
                insert_pending_next = (item.in_byte != FULL_CODE);
            end
        end

        count_upd = (has && (count_reg != '1)) ? count_reg + LENGTH_BITS'(1) : count_reg;

        if (item.frame_last)
        begin
            bytes_left_next     = '0;
            insert_pending_next = 1'b0;
            stopped_next        = 1'b0;
            count_next          = '0;
        end
        else
        begin
            count_next = count_upd;
        end
    end

    generate
        if (LENGTH_BITS > LEN_OUT_W)
        begin : g_clamp
            assign len_clamped = (|count_upd[LENGTH_BITS-1:LEN_OUT_W]) ? '1
                                                                      : count_upd[LEN_OUT_W-1:0];
        end
        else
        begin : g_extend
            assign len_clamped = LEN_OUT_W'(count_upd);
        end
    endgenerate

    assign emit                  = has || item.frame_last;
    assign result.out_byte       = ob;
    assign result.has_byte       = has;
    assign result.frame_end      = item.frame_last;
    assign result.decoded_length = len_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg     <= '0;
            insert_pending_reg <= 1'b0;
            stopped_reg        <= 1'b0;
            count_reg          <= '0;
        end
        else if (advance)
        begin
            bytes_left_reg     <= bytes_left_next;
            insert_pending_reg <= insert_pending_next;
            stopped_reg        <= stopped_next;
            count_reg          <= count_next;
        end
    end

endmodule

>>> rtl/cobs_checker.sv
// Port-level checks for the COBS frame decoder, bound to the top level.
// Depends on cobs_frame_decoder_assert.svh for the assertion macros.
`include "cobs_frame_decoder_assert.svh"

module cobs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        has_byte,
    input logic        frame_end,
    input logic [15:0] decoded_length
);

    `COBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(frame_end))
    `COBS_ASSERT_NOW(a_empty_is_end, out_valid && !has_byte, frame_end)
    `COBS_ASSERT_NOW(a_empty_is_zero, out_valid && !has_byte, out_byte == 8'h00)
    `COBS_ASSERT_NOW(a_len_counts, out_valid && has_byte, decoded_length != 16'h0000)

endmodule

bind cobs_frame_decoder cobs_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .frame_end      (frame_end),
    .decoded_length (decoded_length)
);

>>> bench/testbench.sv
// Self-checking bench for cobs_frame_decoder: drives encoded frames over valid/ready,
// predicts each decoded result in the bench and checks it against the output channel.
// Depends on cobs_pkg and the cobs_frame_decoder RTL.
module testbench;
    import cobs_pkg::*;

    localparam int STALL_CYCLES = 200;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        frame_last;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        frame_end;
    logic [15:0] decoded_length;

    logic [7:0]   dec_reserved;
    logic [7:0]   dec_bytes_left;
    logic         dec_insert_due;
    logic         dec_stopped;
    logic [15:0]  dec_count;
    cobs_result_t pending_results[$];
    cobs_result_t head_result;
    logic [7:0]   encoded[$];
    logic [7:0]   chunk[$];

    logic steady_in;
    logic steady_out;
    int   stall_requests = 0;
    int   stalls_done = 0;
    int   quiet_cycles = 0;
    int   error_count = 0;
    int   bytes_sent;
    int   results_checked = 0;
    int   frames_closed = 0;
    int   cfg_writes;

    cobs_frame_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .has_byte       (has_byte),
        .frame_end      (frame_end),
        .decoded_length (decoded_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        output logic emit, output cobs_result_t r);
        logic       has;
        logic [7:0] ob;
        has = 1'b0;
        ob = '0;
        if (!dec_stopped)
        begin
            if (dec_bytes_left != 0)
            begin
                ob = b;
                has = 1'b1;
                dec_bytes_left = dec_bytes_left - 8'd1;
            end
            else if (b == END_CODE)
            begin
                dec_stopped = 1'b1;
                dec_insert_due = 1'b0;
            end
            else
            begin
                if (dec_insert_due)
                begin
                    ob = dec_reserved;
                    has = 1'b1;
                end
                dec_bytes_left = b - 8'd1;
                dec_insert_due = (b < FULL_CODE);
            end
        end
        if (has && dec_count != COUNT_MAX)
            dec_count = dec_count + 16'd1;
        emit = has || last;
        r.out_byte = ob;
        r.has_byte = has;
        r.frame_end = last;
        r.decoded_length = dec_count;
        if (last)
        begin
            dec_bytes_left = '0;
            dec_insert_due = 1'b0;
            dec_stopped = 1'b0;
            dec_count = '0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic         emit;
        cobs_result_t r;
        while (!steady_in && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        frame_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, last, emit, r);
        if (emit)
            pending_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < encoded.size(); i++)
            send_byte(encoded[i], i == encoded.size() - 1);
    endtask

    task automatic close_block();
        encoded.push_back(8'(chunk.size() + 1));
        foreach (chunk[i])
            encoded.push_back(chunk[i]);
        chunk.delete();
    endtask

    task automatic build_frame(input int len);
        logic [7:0] b;
        encoded.delete();
        chunk.delete();
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(3) == 0) ? dec_reserved : 8'($urandom_range(255));
            if (b == dec_reserved)
                close_block();
            else
            begin
                chunk.push_back(b);
                if (chunk.size() == 254)
                    close_block();
            end
        end
        close_block();
    endtask

    task automatic send_random_frame();
        int len;
        int kind;
        int cut;
        len = ($urandom_range(49) == 0) ? $urandom_range(255, 600) : $urandom_range(0, 20);
        build_frame(len);
        kind = $urandom_range(99);
        if (kind >= 65 && kind < 80)
        begin
            encoded.push_back(END_CODE);
            repeat ($urandom_range(0, 4))
                encoded.push_back(8'($urandom_range(255)));
        end
        else if (kind >= 80 && kind < 92)
        begin
            cut = $urandom_range(1, encoded.size());
            while (encoded.size() > cut)
                void'(encoded.pop_back());
        end
        else if (kind >= 92)
        begin
            encoded.delete();
            repeat ($urandom_range(1, 12))
                encoded.push_back(8'($urandom_range(255)));
        end
        send_stream();
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reserved(input logic [7:0] value);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dec_reserved = value;
        cfg_writes++;
    endtask

    task automatic test_directed_frames();
        // reserved byte still at its reset value; last code byte closes the frame
        encoded = '{8'h03, 8'h11, 8'h22, 8'h02, 8'h33, 8'h01, 8'h01};
        send_stream();
        // zero code stops decoding, trailing bytes dropped
        encoded = '{8'h02, 8'hFF, 8'h00, 8'h55, 8'h00};
        send_stream();
        // zero inside a block, frame cut mid-block
        encoded = '{8'h03, 8'h00, 8'h80, 8'h05, 8'h7F};
        send_stream();
        encoded = '{8'h00};
        send_stream();
        quiesce();
    endtask

    task automatic test_reserved_extremes();
        write_reserved(8'hFF);
        encoded = '{8'h02, 8'hAA, 8'h03, 8'h01, 8'h02, 8'h01};
        send_stream();
        write_reserved(8'h00);
    endtask

    task automatic test_output_stall();
        steady_in = 1'b1;
        stall_requests++;
        repeat (20)
        begin
            encoded = '{8'h02, 8'($urandom_range(255)), 8'h01};
            send_stream();
        end
        steady_in = 1'b0;
        quiesce();
    endtask

    task automatic test_back_to_back();
        int start;
        start = bytes_sent;
        steady_in = 1'b1;
        steady_out = 1'b1;
        while (bytes_sent - start < 300)
            send_random_frame();
        steady_in = 1'b0;
        steady_out = 1'b0;
        quiesce();
    endtask

    task automatic test_random_frames();
        int start;
        int phase;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < 1600)
        begin
            if (bytes_sent - start >= phase * 400)
            begin
                phase++;
                write_reserved(phase == 2 ? 8'hFF : phase == 3 ? 8'h00
                                          : 8'($urandom_range(255)));
            end
            send_random_frame();
        end
        quiesce();
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_requests != stalls_done)
            begin
                stalls_done++;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES - 1)
                    @(posedge clk);
            end
            else
                out_ready <= steady_out || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: out_byte %02h has_byte %0b frame_end %0b",
                       out_byte, has_byte, frame_end);
                error_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (out_byte !== head_result.out_byte)
                begin
                    $error("out_byte expected %02h actual %02h", head_result.out_byte, out_byte);
                    error_count++;
                end
                if (has_byte !== head_result.has_byte)
                begin
                    $error("has_byte expected %0b actual %0b", head_result.has_byte, has_byte);
                    error_count++;
                end
                if (frame_end !== head_result.frame_end)
                begin
                    $error("frame_end expected %0b actual %0b", head_result.frame_end,
                           frame_end);
                    error_count++;
                end
                if (decoded_length !== head_result.decoded_length)
                begin
                    $error("decoded_length expected %0d actual %0d",
                           head_result.decoded_length, decoded_length);
                    error_count++;
                end
                results_checked++;
                if (head_result.frame_end)
                    frames_closed++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_byte <= '0;
        frame_last <= 1'b0;
        steady_in = 1'b0;
        steady_out = 1'b0;
        bytes_sent = 0;
        cfg_writes = 0;
        dec_reserved = '0;
        dec_bytes_left = '0;
        dec_insert_due = 1'b0;
        dec_stopped = 1'b0;
        dec_count = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_reserved_extremes();
        test_output_stall();
        test_back_to_back();
        test_random_frames();

        quiesce();
        $display("summary: %0d bytes in, %0d results checked, %0d frames closed, %0d cfg writes",
                 bytes_sent, results_checked, frames_closed, cfg_writes);
        $display("summary: covered zero codes, cut frames, noise, long output stall, idle gaps");
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
